>>> src/urs_pkg.sv
// ----------------------------------------------------------------------------
// Uniform reservoir sampler package
// Shared widths, item kind codes, register reset value and control structs.
// ----------------------------------------------------------------------------
package urs_pkg;

   localparam int CAPACITY_DEFAULT = 64;
   localparam int RESULT_LIMIT     = 64;

   localparam int VALUE_W = 64;
   localparam int COUNT_W = 64;
   localparam int KIND_W  = 2;
   localparam int SIZE_W  = 7;
   localparam int INDEX_W = 6;

   localparam logic [KIND_W-1:0] KIND_SAMPLE   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SNAPSHOT = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR    = 2'd2;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
      logic clear;
   } mem_ctl_type;

   typedef struct packed {
      logic               start;
      logic [COUNT_W-1:0] dividend;
      logic [COUNT_W-1:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic               done;
      logic [COUNT_W-1:0] remainder;
   } div_res_type;

endpackage

>>> src/urs_ifs.sv
// ----------------------------------------------------------------------------
// Uniform reservoir sampler channels
// Valid/ready channels for request items and response items.
// ----------------------------------------------------------------------------
interface urs_req_if;
   logic                         valid;
   logic                         ready;
   logic [urs_pkg::KIND_W-1:0]   kind;
   logic [urs_pkg::VALUE_W-1:0]  sample_value;
   logic [urs_pkg::COUNT_W-1:0]  random_word;

   modport source (output valid, kind, sample_value, random_word, input ready);
   modport sink (input valid, kind, sample_value, random_word, output ready);
endinterface

interface urs_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [urs_pkg::VALUE_W-1:0]  slot_value;
   logic [urs_pkg::INDEX_W-1:0]  slot_index;
   logic [urs_pkg::COUNT_W-1:0]  seen_count;
   logic                         entry_valid;
   logic                         is_last;

   modport source (output valid, slot_value, slot_index, seen_count, entry_valid, is_last,
                   input ready);
   modport sink (input valid, slot_value, slot_index, seen_count, entry_valid, is_last,
                 output ready);
endinterface

>>> src/urs_div.sv
// ----------------------------------------------------------------------------
// Serial remainder unit
// Restoring division, one quotient bit per cycle, returns the remainder.
// ----------------------------------------------------------------------------
module urs_div (
   input  logic                 clock,
   input  logic                 reset,
   input  urs_pkg::div_cmd_type cmd,
   output urs_pkg::div_res_type res
);

   localparam int W = urs_pkg::COUNT_W;
   localparam int STEP_W = $clog2(W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [W-1:0]      dvd_ff, dvd_in;
   logic [W-1:0]      dsr_ff, dsr_in;
   logic [W-1:0]      rem_ff, rem_in;
   logic [W:0]        trial;
   logic [W:0]        diff;

   assign trial = {rem_ff, dvd_ff[W-1]};
   assign diff  = trial - {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         step_in = '0;
         dvd_in  = cmd.dividend;
         dsr_in  = cmd.divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in  = (trial >= {1'b0, dsr_ff}) ? diff[W-1:0] : trial[W-1:0];
         dvd_in  = {dvd_ff[W-2:0], 1'b0};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      dvd_ff  <= dvd_in;
      dsr_ff  <= dsr_in;
      rem_ff  <= rem_in;
   end

   assign res.done      = done_ff;
   assign res.remainder = rem_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> !busy_ff)
      else $error("Division started while a division is running.");

   a_rem_below: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (rem_ff < dsr_ff))
      else $error("Remainder is not below the divisor.");

endmodule

>>> src/urs_slot_mem.sv
// ----------------------------------------------------------------------------
// Reservoir slot memory
// Synchronous slot store with registered read and per-slot written flags.
// ----------------------------------------------------------------------------
module urs_slot_mem #(
   parameter int SLOTS = urs_pkg::CAPACITY_DEFAULT,
   parameter int IW    = 6
) (
   input  logic                        clock,
   input  logic                        reset,
   input  urs_pkg::mem_ctl_type        ctl,
   input  logic [IW-1:0]               wr_addr,
   input  logic [urs_pkg::VALUE_W-1:0] wr_data,
   input  logic [IW-1:0]               rd_addr,
   output logic [urs_pkg::VALUE_W-1:0] rd_data,
   output logic                        rd_hit
);

   logic [urs_pkg::VALUE_W-1:0] mem [SLOTS];
   logic [SLOTS-1:0]            written_ff;
   logic [urs_pkg::VALUE_W-1:0] rd_data_ff;
   logic                        rd_hit_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_hit_ff  <= written_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         written_ff <= '0;
      end else if (ctl.wr_en) begin
         written_ff[wr_addr] <= 1'b1;
      end
   end

   assign rd_data = rd_data_ff;
   assign rd_hit  = rd_hit_ff;

endmodule

>>> src/uniform_reservoir_sampler.sv
// A fill sample or a clear goes to the emit state, which registers its response item;
// a replacing sample waits in the divide state for the bit-serial 64-bit remainder unit.
// A snapshot registers entries from the slot memory read port, one entry per cycle while
// the output is free, up to 64 entries. One request item is in work at a time.
// Reset: synchronous; the count clears, sample_size returns to 64 and all slots read
// as zero at once through their written flags, so no clearing pass is needed.
// ----------------------------------------------------------------------------
// Uniform reservoir sampler
// Keeps a uniform random sample of a 64-bit value stream in a slot memory.
// ----------------------------------------------------------------------------
module uniform_reservoir_sampler #(
   parameter int CAPACITY = urs_pkg::CAPACITY_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   urs_req_if.sink                    req_bus,
   urs_rsp_if.source                  rsp_bus,
   input  logic                       csr_write_enable,
   input  logic [urs_pkg::SIZE_W-1:0] csr_write_data
);

   localparam int SLOTS = (CAPACITY < urs_pkg::RESULT_LIMIT) ? CAPACITY
                                                             : urs_pkg::RESULT_LIMIT;
   localparam int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int SW    = urs_pkg::SIZE_W;
   localparam int CW    = urs_pkg::COUNT_W;
   localparam logic [SW-1:0] SLOT_LIMIT = SW'(SLOTS);

   typedef enum logic [1:0] {ST_IDLE, ST_DIVIDE, ST_EMIT_ONE, ST_SNAP} state_type;

   state_type                   state_ff, state_in;
   logic [SW-1:0]               size_ff, size_in;
   logic [CW-1:0]               seen_ff, seen_in;
   logic [urs_pkg::VALUE_W-1:0] value_ff, value_in;
   logic [SW-1:0]               idx_ff, idx_in;
   logic [SW-1:0]               filled_ff, filled_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [urs_pkg::VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic [urs_pkg::INDEX_W-1:0] rsp_index_ff, rsp_index_in;
   logic [CW-1:0]               rsp_seen_ff, rsp_seen_in;
   logic                        rsp_ev_ff, rsp_ev_in;
   logic                        rsp_last_ff, rsp_last_in;

   logic [SW-1:0]               size_min;
   logic [SW-1:0]               active_n;
   logic [CW-1:0]               seen_inc;
   logic [CW-1:0]               fill_pos;
   logic [SW-1:0]               idx_next;
   logic                        out_free;
   logic                        snap_last;

   urs_pkg::mem_ctl_type        mem_ctl;
   logic [IW-1:0]               wr_addr;
   logic [urs_pkg::VALUE_W-1:0] wr_data;
   logic [IW-1:0]               rd_addr;
   logic [urs_pkg::VALUE_W-1:0] rd_data;
   logic                        rd_hit;
   urs_pkg::div_cmd_type        div_cmd;
   urs_pkg::div_res_type        div_res;

   assign size_min  = (size_ff == '0) ? SW'(1) : size_ff;
   assign active_n  = (size_min > SLOT_LIMIT) ? SLOT_LIMIT : size_min;
   assign seen_inc  = (seen_ff == '1) ? seen_ff : seen_ff + 1'b1;
   assign fill_pos  = seen_inc - 1'b1;
   assign idx_next  = idx_ff + 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_bus.ready;
   assign snap_last = (idx_ff == filled_ff - 1'b1);

   always_comb begin
      state_in     = state_ff;
      size_in      = size_ff;
      seen_in      = seen_ff;
      value_in     = value_ff;
      idx_in       = idx_ff;
      filled_in    = filled_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_value_in = rsp_value_ff;
      rsp_index_in = rsp_index_ff;
      rsp_seen_in  = rsp_seen_ff;
      rsp_ev_in    = rsp_ev_ff;
      rsp_last_in  = rsp_last_ff;
      mem_ctl      = '0;
      wr_addr      = fill_pos[IW-1:0];
      wr_data      = value_ff;
      rd_addr      = idx_ff[IW-1:0];
      div_cmd.start    = 1'b0;
      div_cmd.dividend = req_bus.random_word;
      div_cmd.divisor  = seen_inc;

      if (csr_write_enable) begin
         size_in = csr_write_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               case (req_bus.kind)
                  urs_pkg::KIND_SAMPLE: begin
                     seen_in  = seen_inc;
                     value_in = req_bus.sample_value;
                     if (seen_inc <= CW'(active_n)) begin
                        mem_ctl.wr_en = 1'b1;
                        wr_data       = req_bus.sample_value;
                        state_in      = ST_EMIT_ONE;
                     end else begin
                        div_cmd.start = 1'b1;
                        state_in      = ST_DIVIDE;
                     end
                  end
                  urs_pkg::KIND_SNAPSHOT: begin
                     filled_in = (seen_ff < CW'(active_n)) ? seen_ff[SW-1:0] : active_n;
                     idx_in    = '0;
                     if (filled_in == '0) begin
                        state_in = ST_EMIT_ONE;
                     end else begin
                        mem_ctl.rd_en = 1'b1;
                        rd_addr       = '0;
                        state_in      = ST_SNAP;
                     end
                  end
                  urs_pkg::KIND_CLEAR: begin
                     seen_in       = '0;
                     mem_ctl.clear = 1'b1;
                     state_in      = ST_EMIT_ONE;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DIVIDE: begin
            if (div_res.done) begin
               if (div_res.remainder < CW'(active_n)) begin
                  mem_ctl.wr_en = 1'b1;
                  wr_addr       = div_res.remainder[IW-1:0];
               end
               state_in = ST_EMIT_ONE;
            end
         end
         ST_EMIT_ONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = '0;
               rsp_index_in = '0;
               rsp_seen_in  = seen_ff;
               rsp_ev_in    = 1'b0;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_SNAP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = rd_hit ? rd_data : '0;
               rsp_index_in = idx_ff[urs_pkg::INDEX_W-1:0];
               rsp_seen_in  = seen_ff;
               rsp_ev_in    = 1'b1;
               rsp_last_in  = snap_last;
               if (snap_last) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in        = idx_next;
                  mem_ctl.rd_en = 1'b1;
                  rd_addr       = idx_next[IW-1:0];
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         size_ff      <= urs_pkg::SIZE_RESET;
         seen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         size_ff      <= size_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      value_ff     <= value_in;
      idx_ff       <= idx_in;
      filled_ff    <= filled_in;
      rsp_value_ff <= rsp_value_in;
      rsp_index_ff <= rsp_index_in;
      rsp_seen_ff  <= rsp_seen_in;
      rsp_ev_ff    <= rsp_ev_in;
      rsp_last_ff  <= rsp_last_in;
   end

   urs_slot_mem #(
      .SLOTS (SLOTS),
      .IW    (IW)
   ) u_slot_mem (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mem_ctl),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .rd_hit  (rd_hit)
   );

   urs_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .res   (div_res)
   );

   assign req_bus.ready       = (state_ff == ST_IDLE);
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.slot_value  = rsp_value_ff;
   assign rsp_bus.slot_index  = rsp_index_ff;
   assign rsp_bus.seen_count  = rsp_seen_ff;
   assign rsp_bus.entry_valid = rsp_ev_ff;
   assign rsp_bus.is_last     = rsp_last_ff;

   a_div_in_state: assert property (@(posedge clock) disable iff (reset)
      div_res.done |-> (state_ff == ST_DIVIDE))
      else $error("Remainder returned outside the divide state.");

   a_read_alone: assert property (@(posedge clock) disable iff (reset)
      mem_ctl.rd_en |-> (!mem_ctl.wr_en && !mem_ctl.clear))
      else $error("Slot read overlaps a slot write or clear.");

   a_plain_item: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ev_ff) |-> (rsp_last_ff && rsp_value_ff == '0))
      else $error("Status item is not a final item with zero value.");

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// Uniform reservoir sampler testbench
// Drives sample, snapshot, clear and unused items through the request channel,
// predicts each response item from a behavioral reservoir copy or a typed table row
// and compares each field. A directed table comes first, then random traffic under
// several sample sizes, with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int CLOCK_PERIOD   = 10;
   localparam int SLOT_LIMIT     =
      (urs_pkg::CAPACITY_DEFAULT < urs_pkg::RESULT_LIMIT) ? urs_pkg::CAPACITY_DEFAULT
                                                          : urs_pkg::RESULT_LIMIT;
   localparam int SETTLE_CYCLES  = 80;
   localparam int RANDOM_ITEMS   = 210;

   localparam int KW = urs_pkg::KIND_W;
   localparam int VW = urs_pkg::VALUE_W;
   localparam int CW = urs_pkg::COUNT_W;
   localparam int IW = urs_pkg::INDEX_W;
   localparam int SW = urs_pkg::SIZE_W;

   localparam logic [KW-1:0] KIND_UNUSED = 2'd3;
   localparam logic [VW-1:0] ALL_ONES    = '1;

   typedef struct packed {
      logic [VW-1:0] slot_value;
      logic [IW-1:0] slot_index;
      logic [CW-1:0] seen_count;
      logic          entry_valid;
      logic          is_last;
   } slot_report_type;

   typedef enum logic {ROW_ITEM, ROW_SIZE} plan_op_type;

   typedef struct packed {
      plan_op_type     op;
      logic [KW-1:0]   kind;
      logic [VW-1:0]   value;
      logic [CW-1:0]   random_word;
      logic            typed;
      slot_report_type report;
   } plan_row_type;

   localparam slot_report_type NO_REPORT    = '0;
   localparam slot_report_type EMPTY_REPORT = '{64'd0, 6'd0, 64'd0, 1'b0, 1'b1};
   localparam slot_report_type ONE_SEEN     = '{64'd0, 6'd0, 64'd1, 1'b0, 1'b1};
   localparam slot_report_type TWO_SEEN     = '{64'd0, 6'd0, 64'd2, 1'b0, 1'b1};

   // For size rows the value column holds the new sample size.
   plan_row_type directed_plan [26] = '{
      '{ROW_ITEM, urs_pkg::KIND_SNAPSHOT, 64'd0, 64'd0, 1'b1, EMPTY_REPORT},
      '{ROW_ITEM, urs_pkg::KIND_SAMPLE, 64'd0, 64'd0, 1'b1, ONE_SEEN},
      '{ROW_ITEM, urs_pkg::KIND_SAMPLE, ALL_ONES, ALL_ONES, 1'b1, TWO_SEEN},
      '{ROW_ITEM, urs_pkg::KIND_SAMPLE, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000,
        1'b0, NO_REPORT},
      '{ROW_ITEM, urs_pkg::KIND_SAMPLE, 64'h0000_0000_0000_0001, 64'h5555_5555_5555_5555,
        1'b0, NO_REPORT},
      '{ROW_ITEM, urs_pkg::KIND_SNAPSHOT, 64'd0, 64'd0, 1'b0, NO_REPORT},
      '{ROW_ITEM, KIND_UNUSED, ALL_ONES, ALL_ONES, 1'b0, NO_REPORT},
      '{ROW_ITEM, urs_pkg::KIND_SNAPSHOT, ALL_ONES, ALL_ONES, 1'b0, NO_REPORT},
      '{ROW_ITEM, urs_pkg::KIND_CLEAR, ALL_ONES, ALL_ONES, 1'b1, EMPTY_REPORT},
      '{ROW_ITEM, urs_pkg::KIND_SNAPSHOT, 64'd0, 64'd0, 1'b1, EMPTY_REPORT},
      '{ROW_ITEM, urs_pkg::KIND_SAMPLE, 64'hA5A5_A5A5_A5A5_A5A5, ALL_ONES, 1'b1, ONE_SEEN},
      '{ROW_SIZE, urs_pkg::KIND_SAMPLE, 64'd1, 64'd0, 1'b0, NO_REPORT},
      '{ROW_ITEM, urs_pkg::KIND_SAMPLE, 64'h0123_4567_89AB_CDEF, 64'd2, 1'b0, NO_REPORT},
      '{ROW_ITEM, urs_pkg::KIND_SAMPLE, 64'hFEDC_BA98_7654_3210, 64'd3, 1'b0, NO_REPORT},
      '{ROW_ITEM, urs_pkg::KIND_SAMPLE, 64'h5A5A_5A5A_5A5A_5A5A, 64'd1, 1'b0, NO_REPORT},
      '{ROW_ITEM, urs_pkg::KIND_SNAPSHOT, 64'd0, 64'd0, 1'b0, NO_REPORT},
      '{ROW_SIZE, urs_pkg::KIND_SAMPLE, 64'd0, 64'd0, 1'b0, NO_REPORT},
      '{ROW_ITEM, urs_pkg::KIND_SAMPLE, 64'h0F0F_0F0F_0F0F_0F0F, 64'd0, 1'b0, NO_REPORT},
      '{ROW_ITEM, urs_pkg::KIND_SNAPSHOT, 64'd0, 64'd0, 1'b0, NO_REPORT},
      '{ROW_SIZE, urs_pkg::KIND_SAMPLE, 64'd127, 64'd0, 1'b0, NO_REPORT},
      '{ROW_ITEM, urs_pkg::KIND_SAMPLE, 64'hC3C3_C3C3_C3C3_C3C3, ALL_ONES, 1'b0, NO_REPORT},
      '{ROW_ITEM, urs_pkg::KIND_SNAPSHOT, 64'd0, 64'd0, 1'b0, NO_REPORT},
      '{ROW_SIZE, urs_pkg::KIND_SAMPLE, 64'd3, 64'd0, 1'b0, NO_REPORT},
      '{ROW_ITEM, urs_pkg::KIND_SNAPSHOT, 64'd0, 64'd0, 1'b0, NO_REPORT},
      '{ROW_SIZE, urs_pkg::KIND_SAMPLE, 64'd64, 64'd0, 1'b0, NO_REPORT},
      '{ROW_ITEM, urs_pkg::KIND_SNAPSHOT, 64'd0, 64'd0, 1'b0, NO_REPORT}
   };

   logic          clock = 1'b0;
   logic          reset;
   logic          csr_write_enable;
   logic [SW-1:0] csr_write_data;

   urs_req_if req ();
   urs_rsp_if rsp ();

   uniform_reservoir_sampler i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req),
      .rsp_bus          (rsp),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   logic [VW-1:0] model_slots [urs_pkg::CAPACITY_DEFAULT];
   logic [CW-1:0] model_seen;
   logic [SW-1:0] model_size;

   slot_report_type expected_reports [$];
   slot_report_type step_reports [$];
   logic            typed_valid;
   slot_report_type typed_report;

   int idle_pct = 19;
   int fault_count;
   int reports_checked;
   int sample_items;
   int snapshot_items;
   int clear_items;
   int ignored_items;
   int size_settings;

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   always @(negedge clock) begin
      if (reset) rsp.ready <= 1'b0;
      else       rsp.ready <= ($urandom_range(0, 99) >= idle_pct);
   end

   initial begin
      #(CLOCK_PERIOD * 1_500_000);
      $display("Run timed out at %0t.", $time);
      $display("Some tests failed");
      $finish;
   end

   function automatic logic [63:0] random_word64();
      return {$urandom, $urandom};
   endfunction

   // Works out the response items of one accepted item and updates the reservoir copy.
   task automatic reservoir_step(input logic [KW-1:0] kind, input logic [VW-1:0] value,
                                 input logic [CW-1:0] random_word);
      logic [CW-1:0] active;
      logic [CW-1:0] filled;
      logic [CW-1:0] pick;
      step_reports.delete();
      active = (model_size == 0) ? 64'd1 : 64'(model_size);
      if (active > CW'(SLOT_LIMIT)) active = CW'(SLOT_LIMIT);
      case (kind)
         urs_pkg::KIND_SAMPLE: begin
            if (model_seen != '1) model_seen++;
            if (model_seen <= active) begin
               model_slots[IW'(model_seen - 1'b1)] = value;
            end else begin
               pick = random_word % model_seen;
               if (pick < active) model_slots[IW'(pick)] = value;
            end
            step_reports.push_back('{64'd0, 6'd0, model_seen, 1'b0, 1'b1});
         end
         urs_pkg::KIND_SNAPSHOT: begin
            filled = (model_seen < active) ? model_seen : active;
            if (filled == 0) step_reports.push_back('{64'd0, 6'd0, model_seen, 1'b0, 1'b1});
            for (int i = 0; i < filled; i++) begin
               step_reports.push_back('{model_slots[IW'(i)], IW'(i), model_seen, 1'b1,
                                        (i + 1 == filled)});
            end
         end
         urs_pkg::KIND_CLEAR: begin
            foreach (model_slots[i]) model_slots[i] = '0;
            model_seen = '0;
            step_reports.push_back(EMPTY_REPORT);
         end
         default: begin
         end
      endcase
   endtask

   task automatic compare_field(input string field, input logic [63:0] want,
                                input logic [63:0] got);
      if (want !== got) begin
         fault_count++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin : scoreboard
      slot_report_type want;
      if (!reset) begin
         if (rsp.valid && rsp.ready) begin
            reports_checked++;
            if (expected_reports.size() == 0) begin
               fault_count++;
               $display("%0t: unexpected response item, expected none, actual value %h",
                        $time, rsp.slot_value);
            end else begin
               want = expected_reports.pop_front();
               compare_field("slot_value", want.slot_value, rsp.slot_value);
               compare_field("slot_index", 64'(want.slot_index), 64'(rsp.slot_index));
               compare_field("seen_count", want.seen_count, rsp.seen_count);
               compare_field("entry_valid", 64'(want.entry_valid), 64'(rsp.entry_valid));
               compare_field("is_last", 64'(want.is_last), 64'(rsp.is_last));
            end
         end
         if (req.valid && req.ready) begin
            case (req.kind)
               urs_pkg::KIND_SAMPLE:   sample_items++;
               urs_pkg::KIND_SNAPSHOT: snapshot_items++;
               urs_pkg::KIND_CLEAR:    clear_items++;
               default:                ignored_items++;
            endcase
            reservoir_step(req.kind, req.sample_value, req.random_word);
            if (typed_valid) expected_reports.push_back(typed_report);
            else foreach (step_reports[i]) expected_reports.push_back(step_reports[i]);
         end
         if (csr_write_enable) model_size = csr_write_data;
      end
   end

   // Called and returns at a falling edge.
   task automatic offer_item(input logic [KW-1:0] kind, input logic [VW-1:0] value,
                             input logic [CW-1:0] random_word, input logic typed,
                             input slot_report_type report);
      int gap;
      gap = 0;
      while ($urandom_range(0, 99) < idle_pct) gap++;
      if (gap != 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req.valid        <= 1'b1;
      req.kind         <= kind;
      req.sample_value <= value;
      req.random_word  <= random_word;
      typed_valid       = typed;
      typed_report      = report;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_for_drain();
      req.valid <= 1'b0;
      while (expected_reports.size() != 0) @(negedge clock);
   endtask

   task automatic write_sample_size(input logic [SW-1:0] size);
      wait_for_drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= size;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      size_settings++;
   endtask

   initial begin
      int useful;
      int phase;
      int roll;
      logic [KW-1:0] kind;
      logic [VW-1:0] value;
      logic [CW-1:0] random_word;

      reset            = 1'b1;
      req.valid        = 1'b0;
      req.kind         = urs_pkg::KIND_SAMPLE;
      req.sample_value = '0;
      req.random_word  = '0;
      csr_write_enable = 1'b0;
      csr_write_data   = urs_pkg::SIZE_RESET;
      typed_valid      = 1'b0;
      typed_report     = NO_REPORT;
      model_seen       = '0;
      model_size       = urs_pkg::SIZE_RESET;
      foreach (model_slots[i]) model_slots[i] = '0;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_plan[i]) begin
         if (directed_plan[i].op == ROW_SIZE)
            write_sample_size(directed_plan[i].value[SW-1:0]);
         else
            offer_item(directed_plan[i].kind, directed_plan[i].value,
                       directed_plan[i].random_word, directed_plan[i].typed,
                       directed_plan[i].report);
      end

      useful = 0;
      phase  = 0;
      while (useful < RANDOM_ITEMS) begin
         if (useful == 60) idle_pct = 0;
         if (useful == 120) idle_pct = 19;
         if (useful >= 50 * (phase + 1)) begin
            phase++;
            case (phase % 4)
               0:       write_sample_size(SW'($urandom_range(2, 63)));
               1:       write_sample_size(7'd1);
               2:       write_sample_size(7'd127);
               default: write_sample_size(7'd64);
            endcase
         end
         roll = $urandom_range(0, 99);
         if (roll < 80)      kind = urs_pkg::KIND_SAMPLE;
         else if (roll < 93) kind = urs_pkg::KIND_SNAPSHOT;
         else if (roll < 96) kind = urs_pkg::KIND_CLEAR;
         else                kind = KIND_UNUSED;
         value = random_word64();
         if ($urandom_range(0, 9) == 0) value = $urandom_range(0, 1) ? ALL_ONES : '0;
         case ($urandom_range(0, 3))
            0, 1:    random_word = random_word64();
            2:       random_word = CW'($urandom_range(0, 255));
            default: random_word = $urandom_range(0, 1) ? ALL_ONES : '0;
         endcase
         offer_item(kind, value, random_word, 1'b0, NO_REPORT);
         if (kind != KIND_UNUSED) useful++;
      end

      wait_for_drain();
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("Covered %0d samples, %0d snapshots, %0d clears and %0d unused-kind items",
               sample_items, snapshot_items, clear_items, ignored_items);
      $display("under %0d sample size settings; %0d response items compared.",
               size_settings, reports_checked);
      if (fault_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

>>> sim.f
src/urs_pkg.sv
src/urs_ifs.sv
src/urs_div.sv
src/urs_slot_mem.sv
src/uniform_reservoir_sampler.sv
tb/tb_top.sv
